### rtl/int32_to_decimal_ascii_assert.svh
// assertion macros for the decimal text converter
`ifndef INT32_TO_DECIMAL_ASCII_ASSERT_SVH
`define INT32_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication
`define I2DA_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("i2da assertion failed");

// next-cycle implication
`define I2DA_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("i2da assertion failed");

`endif

### rtl/i2da_pkg.sv
package i2da_pkg;

	localparam int unsigned NUM_DIGITS = 10;
	localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
	localparam int unsigned RECIP_SHIFT = 35;
	localparam logic [6:0] CH_ZERO = 7'd48;
	localparam logic [6:0] CH_MINUS = 7'd45;

	typedef struct packed {
		logic load;
		logic step;
		logic out_sign;
		logic out_digit;
	} dec_cmd_t;

	typedef struct packed {
		logic neg;
		logic quot_zero;
		logic last_digit;
	} dec_sts_t;

endpackage

### rtl/i2da_dp.sv
module i2da_dp (
	input  logic                 clk,
	input  logic [31:0]          value,
	input  i2da_pkg::dec_cmd_t   cmd,
	output i2da_pkg::dec_sts_t   sts,
	output logic [6:0]           char_code,
	output logic                 is_last,
	output logic [3:0]           char_count
);

	logic [31:0] mag_q;
	logic        neg_q;
	logic [3:0]  dig_q [i2da_pkg::NUM_DIGITS];
	logic [3:0]  nd_q;
	logic [3:0]  ptr_q;

	logic [63:0] prod;
	logic [28:0] quot;
	logic [32:0] quot_ten;
	logic [31:0] rem_full;

	// divide by ten through the reciprocal, exact for all 32-bit values
	always_comb begin
		prod = 64'(mag_q) * 64'(i2da_pkg::RECIP_TEN);
		quot = prod[63:i2da_pkg::RECIP_SHIFT];
		quot_ten = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
		rem_full = mag_q - quot_ten[31:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= value[31];
			mag_q <= value[31] ? (32'd0 - value) : value;
			nd_q <= 4'd0;
		end else if (cmd.step) begin
			dig_q[nd_q] <= rem_full[3:0];
			mag_q <= {3'b000, quot};
			nd_q <= nd_q + 4'd1;
			ptr_q <= nd_q;
		end else if (cmd.out_digit) begin
			ptr_q <= ptr_q - 4'd1;
		end
	end

	assign sts.neg = neg_q;
	assign sts.quot_zero = (quot == 29'd0);
	assign sts.last_digit = (ptr_q == 4'd0);

	assign char_code = cmd.out_sign ? i2da_pkg::CH_MINUS
		: (i2da_pkg::CH_ZERO + {3'b000, dig_q[ptr_q]});
	assign is_last = cmd.out_digit && (ptr_q == 4'd0);
	assign char_count = nd_q + {3'b000, neg_q};

endmodule

### rtl/i2da_ctrl.sv
`include "int32_to_decimal_ascii_assert.svh"

module i2da_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  i2da_pkg::dec_sts_t   sts,
	output i2da_pkg::dec_cmd_t   cmd,
	output logic                 busy,
	output logic                 strobe
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SIGN = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (sts.quot_zero) begin
					state_nxt = sts.neg ? ST_SIGN : ST_EMIT;
				end
			end
			ST_SIGN: begin
				cmd.out_sign = 1'b1;
				state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.out_digit = 1'b1;
				if (sts.last_digit) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign strobe = cmd.out_sign || cmd.out_digit;

	`I2DA_ASSERT_NXT(a_load_div, cmd.load, state_q == ST_DIV)
	`I2DA_ASSERT_NXT(a_sign_digit, cmd.out_sign, cmd.out_digit)
	`I2DA_ASSERT_NXT(a_last_idle, cmd.out_digit && sts.last_digit, !busy)
	`I2DA_ASSERT_IMP(a_beat_busy, strobe, busy && !cmd.step)

endmodule

### rtl/int32_to_decimal_ascii.sv
// channel   signals                                   handshake
// input     value                                     start && !busy
// result    char_code, is_last, char_count            strobe, one cycle each
//
// after acceptance an item takes d divide-by-ten steps (one per digit,
// 1..10) through a single reciprocal multiplier, then c result beats
// (1..11), one per cycle.
// busy is high from the cycle after acceptance through the last beat.
// reset is asynchronous, active low, and returns the controller to idle.
// the receiver cannot stall: every beat is taken in its cycle.
module int32_to_decimal_ascii (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic signed [31:0] value,
	output logic              strobe,
	output logic [6:0]        char_code,
	output logic              is_last,
	output logic [3:0]        char_count
);

	i2da_pkg::dec_cmd_t cmd;
	i2da_pkg::dec_sts_t sts;

	i2da_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.strobe (strobe)
	);

	i2da_dp u_dp (
		.clk        (clk),
		.value      (value),
		.cmd        (cmd),
		.sts        (sts),
		.char_code  (char_code),
		.is_last    (is_last),
		.char_count (char_count)
	);

endmodule

### tb/tb_int32_to_decimal_ascii.sv
module tb_int32_to_decimal_ascii;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned RANDOM_NUMBERS = 340;
	localparam int unsigned QUIET_TAIL = 40;

	typedef struct {
		logic [31:0] val;
		int unsigned gap;
		bit drain;
	} number_req_t;

	typedef struct packed {
		logic [6:0] ch;
		logic last;
		logic [3:0] cnt;
	} char_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic signed [31:0] value = '0;
	logic busy;
	logic strobe;
	logic [6:0] char_code;
	logic is_last;
	logic [3:0] char_count;

	number_req_t numbers_to_send[$];
	char_beat_t expected_text[$];
	int beats_due = 0;
	int beats_seen = 0;
	int errors = 0;
	int unsigned gap_left = 0;
	bit gap_armed = 0;
	int unsigned stall_cycles = 0;

	int32_to_decimal_ascii u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.strobe(strobe),
		.char_code(char_code),
		.is_last(is_last),
		.char_count(char_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// queues the characters of v, sign first, returns how many
	function automatic int render_decimal(input logic [31:0] v);
		logic [31:0] mag;
		logic [3:0] dig[10];
		logic [6:0] txt[11];
		int nd;
		int n;
		char_beat_t b;
		mag = v[31] ? (~v + 32'd1) : v;
		nd = 0;
		do begin
			dig[nd] = 4'(mag % 32'd10);
			mag = mag / 32'd10;
			nd++;
		end while (mag != 0);
		n = 0;
		if (v[31]) begin
			txt[n] = i2da_pkg::CH_MINUS;
			n++;
		end
		for (int k = nd - 1; k >= 0; k--) begin
			txt[n] = i2da_pkg::CH_ZERO + 7'(dig[k]);
			n++;
		end
		for (int k = 0; k < n; k++) begin
			b.ch = txt[k];
			b.last = (k == n - 1);
			b.cnt = 4'(n);
			expected_text.push_back(b);
		end
		return n;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		bit go;
		if (!arst_n) begin
			start <= 1'b0;
			value <= '0;
		end else begin
			go = start;
			if (start && !busy) begin
				beats_due <= beats_due + render_decimal(numbers_to_send[0].val);
				numbers_to_send.pop_front();
				go = 0;
				gap_armed = 0;
			end
			if (!go && numbers_to_send.size() > 0) begin
				if (!gap_armed) begin
					gap_left = numbers_to_send[0].gap;
					gap_armed = 1;
				end
				if (gap_left > 0)
					gap_left--;
				else if (!(numbers_to_send[0].drain && expected_text.size() != 0))
					go = 1;
			end
			start <= go;
			if (go)
				value <= numbers_to_send[0].val;
		end
	end

	// monitor
	always @(posedge clk) begin
		char_beat_t want;
		if (arst_n && strobe) begin
			beats_seen <= beats_seen + 1;
			if (expected_text.size() == 0) begin
				$error("unexpected beat: char_code %0d is_last %0b char_count %0d",
					char_code, is_last, char_count);
				errors++;
			end else begin
				want = expected_text.pop_front();
				if (char_code !== want.ch) begin
					$error("char_code: expected %0d, got %0d", want.ch, char_code);
					errors++;
				end
				if (is_last !== want.last) begin
					$error("is_last: expected %0b, got %0b", want.last, is_last);
					errors++;
				end
				if (char_count !== want.cnt) begin
					$error("char_count: expected %0d, got %0d", want.cnt, char_count);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || strobe)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("int32_to_decimal_ascii regression: fail");
			$finish;
		end
	end

	initial begin
		int directed[] = '{0, 1, -1, 9, 10, -10, 99, 100, -100, 2147483647,
			int'(32'h8000_0000), -2147483647, 999999999, 1000000000, -1000000000,
			1000000009, 123456789, -987654321, 7, -5};
		number_req_t req;
		int unsigned mode;
		int unsigned nd;
		longint unsigned lo;
		longint unsigned hi;
		longint unsigned mag;
		bit neg;

		foreach (directed[i]) begin
			req.val = directed[i];
			req.gap = (i % 3 == 1) ? $urandom_range(19, 1) : 0;
			req.drain = (i == 12);
			numbers_to_send.push_back(req);
		end

		mode = 0;
		for (int i = 0; i < RANDOM_NUMBERS; i++) begin
			if (i % 24 == 0)
				mode = $urandom_range(2, 0);
			neg = $urandom_range(1, 0);
			case ($urandom_range(9, 0))
				0, 1, 2: req.val = $urandom;
				8: begin
					mag = 1;
					repeat ($urandom_range(9, 0)) mag = mag * 10;
					mag = mag + $urandom_range(2, 0) - 1;
					req.val = neg ? -32'(mag) : 32'(mag);
				end
				9: begin
					if (neg)
						req.val = 32'h8000_0000 + $urandom_range(20, 0);
					else
						req.val = 32'h7fff_ffff - $urandom_range(20, 0);
				end
				default: begin
					nd = $urandom_range(10, 1);
					lo = 1;
					repeat (nd - 1) lo = lo * 10;
					hi = lo * 10 - 1;
					if (nd == 1)
						lo = 0;
					if (hi > 64'd2147483647)
						hi = neg ? 64'd2147483648 : 64'd2147483647;
					mag = $urandom_range(32'(hi), 32'(lo));
					req.val = neg ? -32'(mag) : 32'(mag);
				end
			endcase
			if (i >= RANDOM_NUMBERS - QUIET_TAIL)
				req.gap = 0;
			else if ((mode == 1 && $urandom_range(3, 0) == 0) ||
				(mode == 2 && $urandom_range(1, 0) == 1))
				req.gap = $urandom_range(19, 1);
			else
				req.gap = 0;
			req.drain = (i % 61 == 30) && (i < RANDOM_NUMBERS - QUIET_TAIL);
			numbers_to_send.push_back(req);
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (numbers_to_send.size() != 0 || start || beats_seen != beats_due)
			@(negedge clk);
		repeat (30) @(negedge clk);
		if (expected_text.size() != 0) begin
			$error("%0d expected beats never arrived", expected_text.size());
			errors++;
		end
		if (errors == 0)
			$display("int32_to_decimal_ascii regression: pass");
		else
			$display("int32_to_decimal_ascii regression: fail");
		$finish;
	end

endmodule
